/* rtl/l2d_pkg.sv */
package l2d_pkg;

   // Tags carried with every byte.
   localparam logic [2:0] KIND_CONTROL = 3'd0;
   localparam logic [2:0] KIND_SIZE    = 3'd1;
   localparam logic [2:0] KIND_PROPS   = 3'd2;
   localparam logic [2:0] KIND_PACKED  = 3'd3;
   localparam logic [2:0] KIND_RAW     = 3'd4;
   localparam logic [2:0] KIND_END     = 3'd5;
   localparam logic [2:0] KIND_REJECT  = 3'd6;
   localparam logic [2:0] KIND_AFTER   = 3'd7;

   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_CONTROL = 3'd1;
   localparam logic [2:0] ERR_NO_RESET    = 3'd2;
   localparam logic [2:0] ERR_BAD_PROPS   = 3'd3;
   localparam logic [2:0] ERR_STICKY      = 3'd4;

   // Reset level that the stream still owes before the next packed chunk.
   localparam logic [7:0] OWE_FULL  = 8'hE0;
   localparam logic [7:0] OWE_MODEL = 8'hC0;
   localparam logic [7:0] OWE_NONE  = 8'h00;

   localparam logic [7:0] CTL_END        = 8'h00;
   localparam logic [7:0] CTL_RAW_DICT   = 8'h01;
   localparam logic [7:0] CTL_RAW_KEEP   = 8'h02;
   localparam logic [7:0] CTL_STATE_NEW  = 8'hA0;
   localparam logic [7:0] CTL_DICT_NEW   = 8'hE0;
   localparam logic [7:0] PROPS_END      = 8'd225;   // 9 * 5 * 5
   localparam logic [7:0] PROPS_RESET    = 8'd4;

   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = 1;

   typedef struct packed {
      logic [3:0] lc;
      logic [2:0] lp;
      logic [2:0] pb;
   } props_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data;
      logic [2:0]  err;
      logic        hdr;
      logic        reset_dict;
      logic        reset_model;
      logic [21:0] unpacked;
      logic [16:0] packed_len;
      logic        last;
      logic [7:0]  props;
   } rec_type;

   // lc = b % 9, lp = (b / 9) % 5, pb = b / 45, exact for every 8-bit b.
   // b / 9 is (b * 57) >> 9 and q / 5 is (q * 13) >> 6 for q below 29.
   function automatic props_type props_decode(input logic [7:0] b);
      logic [13:0] p9;
      logic [4:0]  q9;
      logic [8:0]  p5;
      logic [7:0]  r9;
      logic [4:0]  r5;
      props_type   res;
      p9 = {6'b0, b} * 14'd57;
      q9 = p9[13:9];
      p5 = {4'b0, q9} * 9'd13;
      res.pb = p5[8:6];
      r9 = b - ({3'b0, q9} * 8'd9);
      r5 = q9 - ({2'b0, p5[8:6]} * 5'd5);
      res.lc = r9[3:0];
      res.lp = r5[2:0];
      return res;
   endfunction

endpackage

/* rtl/l2d_front.sv */
module l2d_front #(
   parameter int LCLP_LIMIT = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             take,
   input  logic [7:0]       data_byte,
   output l2d_pkg::rec_type rec
);

   localparam logic [3:0] PH_CONTROL   = 4'd0;
   localparam logic [3:0] PH_UNPACK_HI = 4'd1;
   localparam logic [3:0] PH_UNPACK_LO = 4'd2;
   localparam logic [3:0] PH_PACK_HI   = 4'd3;
   localparam logic [3:0] PH_PACK_LO   = 4'd4;
   localparam logic [3:0] PH_PROPS     = 4'd5;
   localparam logic [3:0] PH_DATA      = 4'd6;
   localparam logic [3:0] PH_DONE      = 4'd7;
   localparam logic [3:0] PH_ERROR     = 4'd8;

   logic [3:0]  phase_ff, phase_in;
   logic [7:0]  ctl_ff, ctl_in;
   logic [7:0]  owed_ff, owed_in;
   logic [21:0] unp_ff, unp_in;
   logic [16:0] pak_ff, pak_in;
   logic [7:0]  props_ff, props_in;

   logic [2:0]  kind;
   logic [2:0]  err;
   logic        hdr;
   logic        last;
   logic        raw;
   l2d_pkg::props_type cand;
   logic [4:0]  lclp_sum;

   assign cand     = l2d_pkg::props_decode(data_byte);
   assign lclp_sum = {1'b0, cand.lc} + {2'b0, cand.lp};
   assign raw      = ~ctl_in[7];

   always_comb begin
      phase_in = phase_ff;
      ctl_in   = ctl_ff;
      owed_in  = owed_ff;
      unp_in   = unp_ff;
      pak_in   = pak_ff;
      props_in = props_ff;
      kind     = l2d_pkg::KIND_REJECT;
      err      = l2d_pkg::ERR_NONE;
      hdr      = 1'b0;
      last     = 1'b0;
      case (phase_ff)
         PH_CONTROL: begin
            ctl_in = data_byte;
            if (data_byte == l2d_pkg::CTL_END) begin
               kind     = l2d_pkg::KIND_END;
               phase_in = PH_DONE;
            end else if (!data_byte[7]) begin
               if (data_byte > l2d_pkg::CTL_RAW_KEEP) begin
                  err      = l2d_pkg::ERR_BAD_CONTROL;
                  phase_in = PH_ERROR;
               end else if (data_byte == l2d_pkg::CTL_RAW_KEEP &&
                            owed_ff == l2d_pkg::OWE_FULL) begin
                  err      = l2d_pkg::ERR_NO_RESET;
                  phase_in = PH_ERROR;
               end else begin
                  if (data_byte == l2d_pkg::CTL_RAW_DICT) begin
                     owed_in = l2d_pkg::OWE_MODEL;
                  end
                  unp_in   = '0;
                  kind     = l2d_pkg::KIND_CONTROL;
                  phase_in = PH_UNPACK_HI;
               end
            end else if (data_byte < owed_ff) begin
               err      = l2d_pkg::ERR_NO_RESET;
               phase_in = PH_ERROR;
            end else begin
               owed_in  = l2d_pkg::OWE_NONE;
               unp_in   = {1'b0, data_byte[4:0], 16'h0000};
               kind     = l2d_pkg::KIND_CONTROL;
               phase_in = PH_UNPACK_HI;
            end
         end
         PH_UNPACK_HI: begin
            unp_in   = unp_ff | {6'b0, data_byte, 8'h00};
            kind     = l2d_pkg::KIND_SIZE;
            phase_in = PH_UNPACK_LO;
         end
         PH_UNPACK_LO: begin
            // Sizes are stored minus one.
            unp_in = (unp_ff | {14'b0, data_byte}) + 22'd1;
            kind   = l2d_pkg::KIND_SIZE;
            if (!ctl_ff[7]) begin
               pak_in   = '0;
               hdr      = 1'b1;
               phase_in = PH_DATA;
            end else begin
               phase_in = PH_PACK_HI;
            end
         end
         PH_PACK_HI: begin
            pak_in   = {1'b0, data_byte, 8'h00};
            kind     = l2d_pkg::KIND_SIZE;
            phase_in = PH_PACK_LO;
         end
         PH_PACK_LO: begin
            pak_in = (pak_ff | {9'b0, data_byte}) + 17'd1;
            kind   = l2d_pkg::KIND_SIZE;
            if (ctl_ff[6]) begin
               phase_in = PH_PROPS;
            end else begin
               hdr      = 1'b1;
               phase_in = PH_DATA;
            end
         end
         PH_PROPS: begin
            if (data_byte >= l2d_pkg::PROPS_END || lclp_sum > 5'(LCLP_LIMIT)) begin
               err      = l2d_pkg::ERR_BAD_PROPS;
               phase_in = PH_ERROR;
            end else begin
               props_in = data_byte;
               kind     = l2d_pkg::KIND_PROPS;
               hdr      = 1'b1;
               phase_in = PH_DATA;
            end
         end
         PH_DATA: begin
            if (!ctl_ff[7]) begin
               kind   = l2d_pkg::KIND_RAW;
               unp_in = unp_ff - 22'd1;
               last   = (unp_in == '0);
            end else begin
               kind   = l2d_pkg::KIND_PACKED;
               pak_in = pak_ff - 17'd1;
               last   = (pak_in == '0);
            end
            if (last) begin
               phase_in = PH_CONTROL;
            end
         end
         PH_DONE: begin
            kind = l2d_pkg::KIND_AFTER;
         end
         default: begin
            kind     = l2d_pkg::KIND_REJECT;
            err      = l2d_pkg::ERR_STICKY;
            phase_in = PH_ERROR;
         end
      endcase
   end

   always_comb begin
      rec.kind        = kind;
      rec.data        = data_byte;
      rec.err         = err;
      rec.hdr         = hdr;
      rec.reset_dict  = 1'b0;
      rec.reset_model = 1'b0;
      rec.unpacked    = '0;
      rec.packed_len  = '0;
      rec.last        = last;
      rec.props       = props_in;
      if (hdr) begin
         if (raw) begin
            rec.reset_dict = (ctl_in == l2d_pkg::CTL_RAW_DICT);
         end else begin
            rec.reset_dict  = (ctl_in >= l2d_pkg::CTL_DICT_NEW);
            rec.reset_model = (ctl_in >= l2d_pkg::CTL_STATE_NEW);
         end
         rec.unpacked   = unp_in;
         rec.packed_len = pak_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CONTROL;
         ctl_ff   <= 8'h00;
         owed_ff  <= l2d_pkg::OWE_FULL;
         unp_ff   <= '0;
         pak_ff   <= '0;
         props_ff <= l2d_pkg::PROPS_RESET;
      end else if (take) begin
         phase_ff <= phase_in;
         ctl_ff   <= ctl_in;
         owed_ff  <= owed_in;
         unp_ff   <= unp_in;
         pak_ff   <= pak_in;
         props_ff <= props_in;
      end
   end

   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |=> phase_ff == PH_ERROR)
      else $error("error state left without reset");

   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DONE |=> phase_ff == PH_DONE)
      else $error("end state left without reset");

   a_hdr_kind: assert property (@(posedge clock) disable iff (reset)
      take && hdr |-> kind == l2d_pkg::KIND_SIZE || kind == l2d_pkg::KIND_PROPS)
      else $error("header end flagged on a non-header beat");

   a_last_to_control: assert property (@(posedge clock) disable iff (reset)
      take && last |=> phase_ff == PH_CONTROL)
      else $error("chunk end did not return to control byte");

endmodule

/* rtl/l2d_queue.sv */
module l2d_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  l2d_pkg::rec_type push_rec,
   output logic             space,
   input  logic             pop,
   output logic             avail,
   output l2d_pkg::rec_type pop_rec
);

   l2d_pkg::rec_type entry_ff [l2d_pkg::Q_DEPTH];
   logic [l2d_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [l2d_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [l2d_pkg::Q_PTR_W:0]   count_ff, count_in;

   assign space   = (count_ff != (l2d_pkg::Q_PTR_W + 1)'(l2d_pkg::Q_DEPTH));
   assign avail   = (count_ff != '0);
   assign pop_rec = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (l2d_pkg::Q_PTR_W)'(push);
      rd_ptr_in = rd_ptr_ff + (l2d_pkg::Q_PTR_W)'(pop);
      count_in  = count_ff + (l2d_pkg::Q_PTR_W + 1)'(push) - (l2d_pkg::Q_PTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> space)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> avail)
      else $error("queue read while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (l2d_pkg::Q_PTR_W + 1)'(l2d_pkg::Q_DEPTH))
      else $error("queue count out of range");

endmodule

/* rtl/l2d_back.sv */
module l2d_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             avail,
   input  l2d_pkg::rec_type rec,
   output logic             pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [63:0]      rsp_tdata,
   output logic [2:0]       rsp_tuser,
   output logic             rsp_tlast
);

   logic               valid_ff, valid_in;
   logic [63:0]        data_ff, data_in;
   logic [2:0]         user_ff;
   logic               last_ff;
   l2d_pkg::props_type cur;

   assign cur = l2d_pkg::props_decode(rec.props);
   assign pop = avail && (!valid_ff || rsp_tready);

   assign valid_in = pop || (valid_ff && !rsp_tready);
   assign data_in  = {1'b0, rec.packed_len, rec.unpacked, cur.pb, cur.lp, cur.lc,
                      rec.reset_model, rec.reset_dict, rec.hdr, rec.err, rec.data};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         data_ff <= data_in;
         user_ff <= rec.kind;
         last_ff <= rec.last;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* rtl/lzma2_chunk_deframer.sv */
// Channel   Dir  Beat contents
// req_      in   tdata[7:0] stream byte
// rsp_      out  tuser byte kind, tlast last payload byte, tdata fields below
//
// One byte per clock sustained while the queue has space; the front-stage parser
// state updates in the cycle a byte is accepted, so each byte is classified in
// that cycle. Results pass through the queue and then the output register.
// A two-entry queue sits between parser and output register, so input keeps
// flowing while one result waits; req_tready drops only when both are full.
// Reset is synchronous; the block starts awaiting a control byte with a full
// dictionary reset owed and lc 4, lp 0, pb 0.
module lzma2_chunk_deframer #(
   parameter int LCLP_LIMIT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] byte_out, [10:8] error_code, [11] header_done, [12] reset_dict,
   // [13] reset_model, [17:14] lit_context_bits, [20:18] lit_position_bits,
   // [23:21] position_bits, [45:24] unpacked_length, [62:46] packed_length
   output logic [63:0] rsp_tdata,
   output logic [2:0]  rsp_tuser,   // [2:0] byte_kind
   output logic        rsp_tlast    // chunk_last
);

   l2d_pkg::rec_type front_rec;
   l2d_pkg::rec_type back_rec;
   logic             q_space;
   logic             q_avail;
   logic             q_pop;
   logic             push;

   assign req_tready = q_space;
   assign push       = req_tvalid && q_space;

   l2d_front #(
      .LCLP_LIMIT(LCLP_LIMIT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (push),
      .data_byte (req_tdata),
      .rec       (front_rec)
   );

   l2d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (front_rec),
      .space    (q_space),
      .pop      (q_pop),
      .avail    (q_avail),
      .pop_rec  (back_rec)
   );

   l2d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .avail      (q_avail),
      .rec        (back_rec),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* verif/lzma2_deframe_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the deframer, tracks the header parser on its own,
// and compares every result beat field by field with the oldest prediction.
module lzma2_deframe_checker #(
   parameter int LCLP_LIMIT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic [2:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          mismatches,
   output int          outstanding,
   output int          results_seen,
   output logic [7:0]  kinds_seen
);

   typedef enum logic [3:0] {
      ST_CTL, ST_UNP_HI, ST_UNP_LO, ST_PK_HI, ST_PK_LO, ST_PROPS, ST_PAYLOAD, ST_ENDED,
      ST_FAILED
   } parse_state_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data;
      logic [2:0]  err;
      logic        hdr;
      logic        rdict;
      logic        rmodel;
      logic [3:0]  lc;
      logic [2:0]  lp;
      logic [2:0]  pb;
      logic [21:0] unp;
      logic [16:0] pk;
      logic        last;
   } byte_tag_type;

   parse_state_type phase = ST_CTL;
   logic [7:0]   ctl_byte = '0;
   logic [7:0]   owed_level = l2d_pkg::OWE_FULL;
   logic [21:0]  unp_left = '0;
   logic [16:0]  pk_left = '0;
   logic [7:0]   cur_props = l2d_pkg::PROPS_RESET;

   byte_tag_type pending_tags[$];
   int           fail_total = 0;
   int           beat_total = 0;
   int           pending_count = 0;
   logic [7:0]   kind_mask = '0;

   assign mismatches   = fail_total;
   assign outstanding  = pending_count;
   assign results_seen = beat_total;
   assign kinds_seen   = kind_mask;

   task automatic tag_stream_byte(input logic [7:0] b, output byte_tag_type r);
      int lc_val;
      int lp_val;
      r = '0;
      r.data = b;
      r.kind = l2d_pkg::KIND_REJECT;
      r.err = l2d_pkg::ERR_NONE;
      case (phase)
         ST_CTL: begin
            ctl_byte = b;
            if (b == l2d_pkg::CTL_END) begin
               r.kind = l2d_pkg::KIND_END;
               phase = ST_ENDED;
            end else if (!b[7]) begin
               if (b > l2d_pkg::CTL_RAW_KEEP) begin
                  r.err = l2d_pkg::ERR_BAD_CONTROL;
                  phase = ST_FAILED;
               end else if (b == l2d_pkg::CTL_RAW_KEEP && owed_level == l2d_pkg::OWE_FULL) begin
                  r.err = l2d_pkg::ERR_NO_RESET;
                  phase = ST_FAILED;
               end else begin
                  if (b == l2d_pkg::CTL_RAW_DICT) owed_level = l2d_pkg::OWE_MODEL;
                  unp_left = '0;
                  r.kind = l2d_pkg::KIND_CONTROL;
                  phase = ST_UNP_HI;
               end
            end else if (b < owed_level) begin
               r.err = l2d_pkg::ERR_NO_RESET;
               phase = ST_FAILED;
            end else begin
               owed_level = l2d_pkg::OWE_NONE;
               unp_left = {1'b0, b[4:0], 16'h0000};
               r.kind = l2d_pkg::KIND_CONTROL;
               phase = ST_UNP_HI;
            end
         end
         ST_UNP_HI: begin
            unp_left = unp_left | {6'b0, b, 8'h00};
            r.kind = l2d_pkg::KIND_SIZE;
            phase = ST_UNP_LO;
         end
         ST_UNP_LO: begin
            // Sizes are stored minus one, so the bias comes back here.
            unp_left = (unp_left | {14'b0, b}) + 22'd1;
            r.kind = l2d_pkg::KIND_SIZE;
            if (!ctl_byte[7]) begin
               pk_left = '0;
               r.hdr = 1'b1;
               phase = ST_PAYLOAD;
            end else begin
               phase = ST_PK_HI;
            end
         end
         ST_PK_HI: begin
            pk_left = {1'b0, b, 8'h00};
            r.kind = l2d_pkg::KIND_SIZE;
            phase = ST_PK_LO;
         end
         ST_PK_LO: begin
            pk_left = (pk_left | {9'b0, b}) + 17'd1;
            r.kind = l2d_pkg::KIND_SIZE;
            if (ctl_byte[6]) begin
               phase = ST_PROPS;
            end else begin
               r.hdr = 1'b1;
               phase = ST_PAYLOAD;
            end
         end
         ST_PROPS: begin
            lc_val = b % 9;
            lp_val = (b / 9) % 5;
            if (b >= l2d_pkg::PROPS_END || lc_val + lp_val > LCLP_LIMIT) begin
               r.err = l2d_pkg::ERR_BAD_PROPS;
               phase = ST_FAILED;
            end else begin
               cur_props = b;
               r.kind = l2d_pkg::KIND_PROPS;
               r.hdr = 1'b1;
               phase = ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            if (!ctl_byte[7]) begin
               r.kind = l2d_pkg::KIND_RAW;
               unp_left = unp_left - 22'd1;
               r.last = (unp_left == '0);
            end else begin
               r.kind = l2d_pkg::KIND_PACKED;
               pk_left = pk_left - 17'd1;
               r.last = (pk_left == '0);
            end
            if (r.last) phase = ST_CTL;
         end
         ST_ENDED: begin
            r.kind = l2d_pkg::KIND_AFTER;
         end
         default: begin
            r.kind = l2d_pkg::KIND_REJECT;
            r.err = l2d_pkg::ERR_STICKY;
            phase = ST_FAILED;
         end
      endcase
      if (r.hdr) begin
         if (!ctl_byte[7]) begin
            r.rdict = (ctl_byte == l2d_pkg::CTL_RAW_DICT);
            r.rmodel = 1'b0;
         end else begin
            r.rdict = (ctl_byte >= l2d_pkg::CTL_DICT_NEW);
            r.rmodel = (ctl_byte >= l2d_pkg::CTL_STATE_NEW);
         end
         r.unp = unp_left;
         r.pk = pk_left;
      end
      r.lc = 4'(cur_props % 9);
      r.lp = 3'((cur_props / 9) % 5);
      r.pb = 3'(cur_props / 45);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         fail_total++;
         if (fail_total <= 40)
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      byte_tag_type fresh;
      byte_tag_type want;
      if (reset) begin
         phase = ST_CTL;
         ctl_byte = '0;
         owed_level = l2d_pkg::OWE_FULL;
         unp_left = '0;
         pk_left = '0;
         cur_props = l2d_pkg::PROPS_RESET;
         pending_tags.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            tag_stream_byte(req_tdata, fresh);
            pending_tags.push_back(fresh);
         end
         if (rsp_tvalid && rsp_tready) begin
            beat_total++;
            kind_mask[rsp_tuser] = 1'b1;
            if (pending_tags.size() == 0) begin
               fail_total++;
               if (fail_total <= 40)
                  $display("%0t ns: result beat with nothing expected, expected none, got 0x%0h",
                           $time, rsp_tdata);
            end else begin
               want = pending_tags.pop_front();
               check_field("byte_kind", 64'(want.kind), 64'(rsp_tuser));
               check_field("byte_out", 64'(want.data), 64'(rsp_tdata[7:0]));
               check_field("error_code", 64'(want.err), 64'(rsp_tdata[10:8]));
               check_field("header_done", 64'(want.hdr), 64'(rsp_tdata[11]));
               check_field("reset_dict", 64'(want.rdict), 64'(rsp_tdata[12]));
               check_field("reset_model", 64'(want.rmodel), 64'(rsp_tdata[13]));
               check_field("lit_context_bits", 64'(want.lc), 64'(rsp_tdata[17:14]));
               check_field("lit_position_bits", 64'(want.lp), 64'(rsp_tdata[20:18]));
               check_field("position_bits", 64'(want.pb), 64'(rsp_tdata[23:21]));
               check_field("unpacked_length", 64'(want.unp), 64'(rsp_tdata[45:24]));
               check_field("packed_length", 64'(want.pk), 64'(rsp_tdata[62:46]));
               check_field("tdata padding", 64'd0, 64'(rsp_tdata[63]));
               check_field("chunk_last", 64'(want.last), 64'(rsp_tlast));
            end
         end
      end
      pending_count = pending_tags.size();
   end

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

   localparam int LCLP = 4;
   localparam int CYCLE_LIMIT = 200_000;
   localparam int RANDOM_BYTES = 420;
   localparam logic [7:0] CTL_PLAIN = 8'h80;   // packed chunk, no reset

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   int          mismatches;
   int          outstanding;
   int          results_seen;
   logic [7:0]  kinds_seen;

   logic [7:0]  stream_bytes[$];
   bit          steady_flags[$];
   logic [7:0]  plan_owed = l2d_pkg::OWE_FULL;
   int          chunk_count = 0;
   int          byte_total = 0;
   string       tail_name = "";
   int          cycle_count = 0;

   logic [1:0]  ready_mode = 2'd0;
   logic [7:0]  ready_mask = 8'h01;
   int          mode_left = 0;

   always #4 clock = ~clock;

   lzma2_chunk_deframer #(.LCLP_LIMIT(LCLP)) uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   lzma2_deframe_checker #(.LCLP_LIMIT(LCLP)) u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .mismatches(mismatches), .outstanding(outstanding),
      .results_seen(results_seen), .kinds_seen(kinds_seen)
   );

   // The receiver switches between always ready, random stalls and a rotating
   // mask; the mask always keeps one bit set, so every stall in that mode ends.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= 2'($urandom_range(0, 2));
         ready_mask <= 8'($urandom_range(0, 255)) | 8'h01;
         mode_left <= $urandom_range(32, 400);
      end else begin
         ready_mask <= {ready_mask[0], ready_mask[7:1]};
         mode_left <= mode_left - 1;
      end
      case (ready_mode)
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ready_mask[0];
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, outstanding);
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [7:0] props_of(input int lc, input int lp, input int pb);
      return 8'((pb * 5 + lp) * 9 + lc);
   endfunction

   function automatic logic [7:0] legal_props();
      int lc;
      int lp;
      lc = $urandom_range(0, LCLP);
      lp = $urandom_range(0, LCLP - lc);
      return props_of(lc, lp, $urandom_range(0, 4));
   endfunction

   task automatic put_byte(input logic [7:0] b, input bit hold);
      stream_bytes.push_back(b);
      steady_flags.push_back(hold);
   endtask

   task automatic send_raw(input logic [7:0] ctl, input logic [15:0] size_m1, input bit hold);
      put_byte(ctl, 1'b0);
      put_byte(size_m1[15:8], 1'b0);
      put_byte(size_m1[7:0], 1'b0);
      for (int i = 0; i <= size_m1; i++) put_byte(8'($urandom_range(0, 255)), hold);
      if (ctl == l2d_pkg::CTL_RAW_DICT) plan_owed = l2d_pkg::OWE_MODEL;
      chunk_count++;
   endtask

   task automatic send_packed(input logic [7:0] ctl, input logic [15:0] unp,
                              input logic [15:0] pk_m1, input logic [7:0] props,
                              input bit hold);
      put_byte(ctl, 1'b0);
      put_byte(unp[15:8], 1'b0);
      put_byte(unp[7:0], 1'b0);
      put_byte(pk_m1[15:8], 1'b0);
      put_byte(pk_m1[7:0], 1'b0);
      if (ctl[6]) put_byte(props, 1'b0);
      for (int i = 0; i <= pk_m1; i++) put_byte(8'($urandom_range(0, 255)), hold);
      plan_owed = l2d_pkg::OWE_NONE;
      chunk_count++;
   endtask

   // Picks a chunk that the reset order still allows, with mostly short payloads.
   task automatic send_legal_chunk();
      int pick;
      logic [7:0] top;
      logic [15:0] len_m1;
      pick = $urandom_range(0, 5);
      len_m1 = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(16, 300))
                                            : 16'($urandom_range(0, 15));
      if (pick == 0 || (pick == 1 && plan_owed == l2d_pkg::OWE_FULL)) begin
         send_raw(l2d_pkg::CTL_RAW_DICT, len_m1, 1'b0);
      end else if (pick == 1) begin
         send_raw(l2d_pkg::CTL_RAW_KEEP, len_m1, 1'b0);
      end else begin
         case ($urandom_range(0, 3))
            0: top = CTL_PLAIN;
            1: top = l2d_pkg::CTL_STATE_NEW;
            2: top = l2d_pkg::OWE_MODEL;
            default: top = l2d_pkg::CTL_DICT_NEW;
         endcase
         if (top < plan_owed)
            top = ($urandom_range(0, 1) != 0) ? l2d_pkg::OWE_MODEL : l2d_pkg::CTL_DICT_NEW;
         if (top < plan_owed) top = l2d_pkg::CTL_DICT_NEW;
         send_packed(top | 8'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)), len_m1,
                     legal_props(), 1'b0);
      end
   endtask

   // Ends the stream with one of the conditions that hold until reset.
   task automatic send_tail();
      int lc;
      case ($urandom_range(0, 3))
         0: begin
            tail_name = "end marker";
            put_byte(l2d_pkg::CTL_END, 1'b0);
         end
         1: begin
            tail_name = "bad control byte";
            put_byte(8'($urandom_range(l2d_pkg::CTL_RAW_KEEP + 1, CTL_PLAIN - 1)), 1'b0);
         end
         2: begin
            tail_name = "missing state reset";
            send_raw(l2d_pkg::CTL_RAW_DICT, 16'($urandom_range(0, 7)), 1'b0);
            put_byte(8'($urandom_range(CTL_PLAIN, l2d_pkg::OWE_MODEL - 1)), 1'b0);
         end
         default: begin
            tail_name = "bad props byte";
            put_byte(l2d_pkg::CTL_DICT_NEW | 8'($urandom_range(0, 31)), 1'b0);
            repeat (4) put_byte(8'($urandom_range(0, 255)), 1'b0);
            if ($urandom_range(0, 1) != 0) begin
               put_byte(8'($urandom_range(l2d_pkg::PROPS_END, 255)), 1'b0);
            end else begin
               lc = $urandom_range(1, 8);
               put_byte(props_of(lc, $urandom_range((lc > LCLP) ? 0 : LCLP + 1 - lc, 4),
                                 $urandom_range(0, 4)), 1'b0);
            end
         end
      endcase
      repeat ($urandom_range(6, 20)) put_byte(8'($urandom_range(0, 255)), 1'b0);
   endtask

   initial begin
      int burst;
      int gap;
      int directed_len;
      bit hold;

      // Directed: smallest chunks, every control class, props extremes, the
      // largest declared unpacked size, and longer packed and raw chunks sent
      // without sender gaps.
      send_raw(l2d_pkg::CTL_RAW_DICT, 16'h0000, 1'b0);
      send_packed(l2d_pkg::OWE_MODEL, 16'h0000, 16'h0000, props_of(0, 0, 0), 1'b0);
      send_raw(l2d_pkg::CTL_RAW_KEEP, 16'h0001, 1'b0);
      send_packed(CTL_PLAIN | 8'h1F, 16'hFFFF, 16'h0001, 8'h00, 1'b0);
      send_packed(l2d_pkg::CTL_STATE_NEW, 16'h1234, 16'h0000, 8'h00, 1'b0);
      send_packed(l2d_pkg::CTL_DICT_NEW, 16'hA5C3, 16'h0002, props_of(0, 4, 4), 1'b0);
      send_packed(8'hFF, 16'hFFFF, 16'h003F, props_of(4, 0, 4), 1'b1);
      send_raw(l2d_pkg::CTL_RAW_DICT, 16'h003F, 1'b1);
      send_packed(l2d_pkg::OWE_MODEL | 8'h15, 16'h00FF, 16'h0000, props_of(2, 2, 2), 1'b0);
      directed_len = stream_bytes.size();

      while (stream_bytes.size() < directed_len + RANDOM_BYTES) send_legal_chunk();
      send_tail();
      byte_total = stream_bytes.size();

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (stream_bytes.size() != 0) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
         while (burst != 0 && stream_bytes.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= stream_bytes.pop_front();
            hold = steady_flags.pop_front();
            do @(posedge clock); while (!req_tready);
            if (!hold) burst--;
         end
         gap = $urandom_range(0, 5);
         if (gap != 0 && stream_bytes.size() != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("Sent %0d stream bytes in %0d chunks, closed by a %s; %0d result beats compared.",
               byte_total, chunk_count, tail_name, results_seen);
      $display("Byte kinds seen on the result side (bit per kind): %b", kinds_seen);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/l2d_pkg.sv
rtl/l2d_front.sv
rtl/l2d_queue.sv
rtl/l2d_back.sv
rtl/lzma2_chunk_deframer.sv
verif/lzma2_deframe_checker.sv
verif/tb.sv
